>>> design/assert_macros.svh
// assertion macros for the design files
// no dependencies; assertions vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(lbl, clk, rst, expr, msg)
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/sdpa_pkg.sv
// constants, state encoding and helper functions for the density accumulator
// no dependencies
package sdpa_pkg;

  localparam int unsigned MAX_KEPT = 64;
  localparam int unsigned KEEP_CAP = (MAX_KEPT < 127) ? MAX_KEPT : 127;

  localparam logic [31:0] SAT32        = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT    = 32'h8000_0000;
  localparam logic [63:0] NEAR_ZERO_R2 = 64'd43;
  localparam logic [16:0] ONE_Q16      = 17'h1_0000;
  localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

  // configuration register indexes
  localparam logic [2:0] REG_RADIUS     = 3'd0;
  localparam logic [2:0] REG_INV_RADIUS = 3'd1;
  localparam logic [2:0] REG_DENS_GAIN  = 3'd2;
  localparam logic [2:0] REG_NEAR_GAIN  = 3'd3;
  localparam logic [2:0] REG_STIFF      = 3'd4;
  localparam logic [2:0] REG_REST       = 3'd5;
  localparam logic [2:0] REG_NEAR_STIFF = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ABS,
    ST_RANGE,
    ST_SQY,
    ST_SQH,
    ST_CUT,
    ST_SQRT,
    ST_RINV,
    ST_A,
    ST_AA,
    ST_A2,
    ST_A3,
    ST_MD,
    ST_DT,
    ST_MN,
    ST_NT,
    ST_FINISH,
    ST_PMAG,
    ST_PMUL,
    ST_PRES,
    ST_NPRES,
    ST_EMIT
  } sdpa_state_t;

  // saturating accumulate into a non-negative 32-bit sum
  function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [45:0] term);
    logic [46:0] s;
    s = {15'd0, acc} + {1'b0, term};
    return (s > {15'd0, SAT32}) ? SAT32 : s[31:0];
  endfunction

  // q16.16 product shifted down, negated if needed, saturated to signed 32 bits
  function automatic logic [31:0] mul_sat(input logic neg, input logic [63:0] p);
    logic [47:0] m;
    m = p[63:16];
    if (neg) begin
      return (m > {16'd0, NEG_LIMIT}) ? NEG_LIMIT : (~m[31:0] + 32'd1);
    end
    return (m > {16'd0, SAT32}) ? SAT32 : m[31:0];
  endfunction

endpackage

>>> design/sdpa_in_if.sv
// neighbor item channel: valid/ready handshake plus position and mass payload
// no dependencies
interface sdpa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] neighbor_x;
  logic signed [31:0] neighbor_y;
  logic        [30:0] neighbor_mass;
  logic               last_neighbor;

  modport source (output valid, center_x, center_y, neighbor_x, neighbor_y,
                  neighbor_mass, last_neighbor, input ready);
  modport sink   (input valid, center_x, center_y, neighbor_x, neighbor_y,
                  neighbor_mass, last_neighbor, output ready);
endinterface

>>> design/sdpa_out_if.sv
// result item channel: valid/ready handshake plus densities, pressures, count
// no dependencies
interface sdpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] density;
  logic signed [31:0] near_density;
  logic signed [31:0] pressure;
  logic signed [31:0] near_pressure;
  logic        [6:0]  kept_count;

  modport source (output valid, density, near_density, pressure, near_pressure,
                  kept_count, input ready);
  modport sink   (input valid, density, near_density, pressure, near_pressure,
                  kept_count, output ready);
endinterface

>>> design/sdpa_cfg_if.sv
// configuration write channel: valid/ready handshake, register index and data
// no dependencies
interface sdpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [30:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/sph_density_pressure_accumulator_top.sv
// Density / near-density accumulator for one centre particle over a run of
// neighbor items, all Q16.16. Each neighbor item is worked through one shared
// 32x32 multiplier and a one-bit-pair-per-cycle square root under a small
// sequencer, and the block takes no new item while it works. A neighbor that
// passes the radius test goes on through the square root and the kernel
// products; one rejected by the per-axis test or by the squared distance test
// goes straight to the finish state. The item marked last then passes the two
// pressure products and the result register, and waits there if the previous
// result has not yet been taken. Configuration writes are always accepted and
// belong in idle periods only.
//
// depends on sdpa_pkg, sdpa_in_if, sdpa_out_if, sdpa_cfg_if, assert_macros.svh
`include "assert_macros.svh"

module sph_density_pressure_accumulator_top
  import sdpa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sdpa_cfg_if.sink      cfg,
  sdpa_in_if.sink       neighbor,
  sdpa_out_if.source    result
);

  sdpa_state_t state, state_next;

  // configuration registers
  logic [30:0] radius, inv_radius, dens_gain, near_gain, stiff, rest, near_stiff;

  // item registers
  logic [32:0] dx, dy;
  logic [31:0] adx, ady;
  logic [30:0] mass;
  logic        last_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // square root
  logic [63:0] r2, rem, root, bitq, trial;
  logic [4:0]  sqrt_cnt;

  logic [16:0] a_q, a2_q, a3_q;
  logic [31:0] density_sum, near_density_sum;
  logic [6:0]  kept_counter;
  logic [32:0] pdiff;
  logic [31:0] pmag;
  logic        pneg;
  logic [31:0] pressure_q;
  logic [31:0] near_pressure_q;

  logic        in_acc, can_emit, range_ok, cut_ok;

  assign cfg.ready = 1'b1;
  assign in_acc    = neighbor.valid && neighbor.ready;
  assign can_emit  = !result.valid || result.ready;
  assign range_ok  = (adx <= {1'b0, radius}) && (ady <= {1'b0, radius});
  assign cut_ok    = (r2 >= NEAR_ZERO_R2) && (r2 <= prod);
  assign trial     = root + bitq;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= 31'd65536;
      inv_radius <= 31'd65536;
      dens_gain  <= 31'd208605;
      near_gain  <= 31'd312907;
      stiff      <= 31'd65536;
      rest       <= 31'd655360;
      near_stiff <= 31'd65536;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RADIUS:     radius     <= cfg.data;
        REG_INV_RADIUS: inv_radius <= cfg.data;
        REG_DENS_GAIN:  dens_gain  <= cfg.data;
        REG_NEAR_GAIN:  near_gain  <= cfg.data;
        REG_STIFF:      stiff      <= cfg.data;
        REG_REST:       rest       <= cfg.data;
        REG_NEAR_STIFF: near_stiff <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = ST_ABS;
      ST_ABS:    state_next = ST_RANGE;
      ST_RANGE:  state_next = range_ok ? ST_SQY : ST_FINISH;
      ST_SQY:    state_next = ST_SQH;
      ST_SQH:    state_next = ST_CUT;
      ST_CUT:    state_next = cut_ok ? ST_SQRT : ST_FINISH;
      ST_SQRT:   if (sqrt_cnt == 5'd31) state_next = ST_RINV;
      ST_RINV:   state_next = ST_A;
      ST_A:      state_next = ST_AA;
      ST_AA:     state_next = ST_A2;
      ST_A2:     state_next = ST_A3;
      ST_A3:     state_next = ST_MD;
      ST_MD:     state_next = ST_DT;
      ST_DT:     state_next = ST_MN;
      ST_MN:     state_next = ST_NT;
      ST_NT:     state_next = ST_FINISH;
      ST_FINISH: state_next = last_q ? ST_PMAG : ST_IDLE;
      ST_PMAG:   state_next = ST_PMUL;
      ST_PMUL:   state_next = ST_PRES;
      ST_PRES:   state_next = ST_NPRES;
      ST_NPRES:  state_next = ST_EMIT;
      ST_EMIT:   if (can_emit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // multiplier operands and handshake
  always_comb begin
    neighbor.ready = (state == ST_IDLE);
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      ST_RANGE: begin mul_a = adx;                     mul_b = adx;                     end
      ST_SQY:   begin mul_a = ady;                     mul_b = ady;                     end
      ST_SQH:   begin mul_a = {1'b0, radius};          mul_b = {1'b0, radius};          end
      ST_RINV:  begin mul_a = root[31:0];              mul_b = {1'b0, inv_radius};      end
      ST_AA:    begin mul_a = {15'd0, a_q};            mul_b = {15'd0, a_q};            end
      ST_A2:    begin mul_a = {15'd0, prod[32:16]};    mul_b = {15'd0, a_q};            end
      ST_A3:    begin mul_a = {1'b0, mass};            mul_b = {15'd0, a2_q};           end
      ST_MD:    begin mul_a = {1'b0, prod[46:16]};     mul_b = {1'b0, dens_gain};       end
      ST_DT:    begin mul_a = {1'b0, mass};            mul_b = {15'd0, a3_q};           end
      ST_MN:    begin mul_a = {1'b0, prod[46:16]};     mul_b = {1'b0, near_gain};       end
      ST_PMUL:  begin mul_a = pmag;                    mul_b = {1'b0, stiff};           end
      ST_PRES:  begin mul_a = near_density_sum;        mul_b = {1'b0, near_stiff};      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          dx     <= {neighbor.neighbor_x[31], neighbor.neighbor_x}
                    - {neighbor.center_x[31], neighbor.center_x};
          dy     <= {neighbor.neighbor_y[31], neighbor.neighbor_y}
                    - {neighbor.center_y[31], neighbor.center_y};
          mass   <= neighbor.neighbor_mass;
          last_q <= neighbor.last_neighbor;
        end
      end
      ST_ABS: begin
        adx <= dx[32] ? 32'(-dx) : dx[31:0];
        ady <= dy[32] ? 32'(-dy) : dy[31:0];
      end
      ST_SQY: r2 <= prod;
      ST_SQH: r2 <= r2 + prod;
      ST_CUT: begin
        rem      <= r2;
        root     <= 64'd0;
        bitq     <= SQRT_TOP_BIT;
        sqrt_cnt <= 5'd0;
      end
      ST_SQRT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitq;
        end else begin
          root <= root >> 1;
        end
        bitq     <= bitq >> 2;
        sqrt_cnt <= sqrt_cnt + 5'd1;
      end
      // a = 1 - r/h, clamped at zero
      ST_A:    a_q <= (prod[63:32] != 32'd0) ? 17'd0 : (ONE_Q16 - {1'b0, prod[31:16]});
      ST_A2:   a2_q <= prod[32:16];
      ST_A3:   a3_q <= prod[32:16];
      ST_FINISH: pdiff <= {1'b0, density_sum} - {2'b00, rest};
      ST_PMAG: begin
        pmag <= pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
        pneg <= pdiff[32];
      end
      ST_PRES:  pressure_q <= mul_sat(pneg, prod);
      ST_NPRES: near_pressure_q <= mul_sat(1'b0, prod);
      default: ;
    endcase
  end

  // accumulators and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      density_sum      <= 32'd0;
      near_density_sum <= 32'd0;
      kept_counter     <= 7'd0;
      result.valid     <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (state == ST_DT) begin
        density_sum <= sat_add(density_sum, prod[61:16]);
      end
      if (state == ST_NT) begin
        near_density_sum <= sat_add(near_density_sum, prod[61:16]);
        if (kept_counter < 7'(KEEP_CAP)) begin
          kept_counter <= kept_counter + 7'd1;
        end
      end
      if (state == ST_EMIT && can_emit) begin
        result.valid         <= 1'b1;
        result.density       <= density_sum;
        result.near_density  <= near_density_sum;
        result.pressure      <= pressure_q;
        result.near_pressure <= near_pressure_q;
        result.kept_count    <= kept_counter;
        density_sum          <= 32'd0;
        near_density_sum     <= 32'd0;
        kept_counter         <= 7'd0;
      end
    end
  end

  `CHK_ALWAYS(a_cnt_cap, clk, rst, kept_counter <= 7'(KEEP_CAP), "kept counter above cap")
  `CHK_ALWAYS(a_sum_pos, clk, rst, !density_sum[31] && !near_density_sum[31], "sum overflowed")
  `CHK_NEXT(a_sqrt_end, clk, rst, state == ST_SQRT && sqrt_cnt == 5'd31, state == ST_RINV,
            "square root did not finish after 32 steps")
  `CHK_NEXT(a_emit_clr, clk, rst, state == ST_EMIT && can_emit,
            result.valid && density_sum == 32'd0 && kept_counter == 7'd0,
            "state not cleared on result")
  `CHK_NEXT(a_busy, clk, rst, state != ST_IDLE && state != ST_EMIT && state != ST_FINISH,
            state != ST_IDLE || $past(state) == ST_FINISH || $past(state) == ST_EMIT,
            "returned to idle mid-item")

endmodule

>>> verif/sph_density_pressure_accumulator_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the sph density / pressure accumulator top
// depends on sdpa_pkg, sdpa_in_if, sdpa_out_if, sdpa_cfg_if and the accumulator top; reads no files

module sph_density_pressure_accumulator_top_tb;
  import sdpa_pkg::*;

  localparam int DRAIN_CYCLES = 100;   // worst neighbor plus pressure stage, with margin
  localparam int STALL_LIMIT  = 4000;  // cycles with no item moving on any channel

  localparam longint      POS_MAX  = 64'sd2147483647;
  localparam longint      NEG_MAX  = -64'sd2147483648;
  localparam logic [30:0] REG_MAX  = 31'h7FFF_FFFF;
  localparam logic [30:0] MASS_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [30:0] radius;
    logic [30:0] inv_radius;
    logic [30:0] dens_gain;
    logic [30:0] near_gain;
    logic [30:0] stiff;
    logic [30:0] rest;
    logic [30:0] near_stiff;
  } setting_t;

  localparam setting_t RESET_SETTING = '{31'd65536, 31'd65536, 31'd208605, 31'd312907,
                                         31'd65536, 31'd655360, 31'd65536};

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        mass;
    bit                 last;
  } neighbor_t;

  typedef struct {
    logic [31:0] density;
    logic [31:0] near_density;
    logic [31:0] pressure;
    logic [31:0] near_pressure;
    logic [6:0]  kept_count;
  } densities_t;

  logic clk;
  logic rst;

  sdpa_cfg_if cfg_bus();
  sdpa_in_if  nbr_bus();
  sdpa_out_if res_bus();

  sph_density_pressure_accumulator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_bus),
    .neighbor (nbr_bus),
    .result   (res_bus)
  );

  // predictor state, mirrors the block's registers
  setting_t    cur;
  logic [31:0] acc_density;
  logic [31:0] acc_near;
  logic [6:0]  acc_kept;

  densities_t expected_results[$];
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  bit         steady_flow    = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] add_saturated(input logic [31:0] acc, input logic [63:0] term);
    logic [63:0] s;
    s = 64'(acc) + term;
    return (s > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
  endfunction

  // signed q16.16 product, truncated toward zero, clamped to 32 bits
  function automatic logic [31:0] scale_pressure(input longint diff, input logic [30:0] gain);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = (mag * 64'(gain)) >> 16;
    if (diff < 0) return (prod > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - prod);
    return (prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
  endfunction

  task automatic predict_densities(input neighbor_t n);
    longint      dx;
    longint      dy;
    logic [63:0] adx, ady, lim, r2, r, t, a, a2, a3, dterm, nterm;
    densities_t  res;
    dx  = longint'(n.nx) - longint'(n.cx);
    dy  = longint'(n.ny) - longint'(n.cy);
    adx = (dx < 0) ? 64'(-dx) : 64'(dx);
    ady = (dy < 0) ? 64'(-dy) : 64'(dy);
    lim = 64'(cur.radius);
    if (adx <= lim && ady <= lim) begin
      r2 = adx * adx + ady * ady;
      if (r2 >= NEAR_ZERO_R2 && r2 <= lim * lim) begin
        r  = floor_sqrt(r2);
        t  = (r * 64'(cur.inv_radius)) >> 16;
        a  = (t >= 64'(ONE_Q16)) ? 64'd0 : 64'(ONE_Q16) - t;
        a2 = (a * a) >> 16;
        a3 = (a2 * a) >> 16;
        dterm = (((64'(n.mass) * a2) >> 16) * 64'(cur.dens_gain)) >> 16;
        nterm = (((64'(n.mass) * a3) >> 16) * 64'(cur.near_gain)) >> 16;
        acc_density = add_saturated(acc_density, dterm);
        acc_near    = add_saturated(acc_near, nterm);
        if (acc_kept < KEEP_CAP) acc_kept++;
      end
    end
    if (n.last) begin
      res.density       = acc_density;
      res.near_density  = acc_near;
      res.pressure      = scale_pressure(longint'(acc_density) - longint'(cur.rest), cur.stiff);
      res.near_pressure = scale_pressure(longint'(acc_near), cur.near_stiff);
      res.kept_count    = acc_kept;
      expected_results.push_back(res);
      acc_density = '0;
      acc_near    = '0;
      acc_kept    = '0;
    end
  endtask

  function automatic neighbor_t make_neighbor(input longint cx, input longint cy,
                                              input longint nx, input longint ny,
                                              input logic [30:0] mass, input bit last);
    neighbor_t n;
    n.cx   = 32'(cx);
    n.cy   = 32'(cy);
    n.nx   = 32'(nx);
    n.ny   = 32'(ny);
    n.mass = mass;
    n.last = last;
    return n;
  endfunction

  // mostly neighbors scattered around the cutoff, some nearly coincident, some anywhere
  function automatic neighbor_t random_neighbor(input bit last);
    longint      cx, cy, ox, oy, span;
    logic [30:0] mass;
    int          roll;
    roll = $urandom_range(0, 99);
    cx   = longint'($signed($urandom)) >>> $urandom_range(0, 2);
    cy   = longint'($signed($urandom)) >>> $urandom_range(0, 2);
    span = longint'(cur.radius) + (longint'(cur.radius) >>> 2);
    if (span > POS_MAX) span = POS_MAX;
    if ($urandom_range(0, 1) == 1) span = span >>> $urandom_range(1, 12);
    if (roll < 12) begin
      ox = longint'($signed($urandom));
      oy = longint'($signed($urandom));
    end else if (roll < 20) begin
      ox = longint'($urandom_range(0, 14)) - 7;
      oy = longint'($urandom_range(0, 14)) - 7;
    end else begin
      ox = longint'($urandom_range(0, 32'(2 * span))) - span;
      oy = longint'($urandom_range(0, 32'(2 * span))) - span;
    end
    mass = 31'($urandom);
    if ($urandom_range(0, 3) != 0) mass = mass >> $urandom_range(1, 20);
    return make_neighbor(cx, cy, cx + ox, cy + oy, mass, last);
  endfunction

  function automatic setting_t random_setting();
    setting_t    s;
    logic [63:0] inv;
    s.radius = 31'($urandom) >> $urandom_range(6, 26);
    if (s.radius == 0) s.radius = 1;
    inv = (64'd1 << 32) / 64'(s.radius);
    if ($urandom_range(0, 2) == 0) inv = 64'(31'($urandom) >> $urandom_range(0, 30));
    if (inv > 64'(REG_MAX)) inv = 64'(REG_MAX);
    if (inv == 0) inv = 1;
    s.inv_radius = inv[30:0];
    s.dens_gain  = 31'($urandom) >> $urandom_range(0, 30);
    s.near_gain  = 31'($urandom) >> $urandom_range(0, 30);
    s.stiff      = 31'($urandom) >> $urandom_range(0, 30);
    s.rest       = 31'($urandom) >> $urandom_range(0, 30);
    s.near_stiff = 31'($urandom) >> $urandom_range(0, 30);
    return s;
  endfunction

  task automatic send_neighbor(input neighbor_t n);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      nbr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nbr_bus.valid         <= 1'b1;
    nbr_bus.center_x      <= n.cx;
    nbr_bus.center_y      <= n.cy;
    nbr_bus.neighbor_x    <= n.nx;
    nbr_bus.neighbor_y    <= n.ny;
    nbr_bus.neighbor_mass <= n.mass;
    nbr_bus.last_neighbor <= n.last;
    do @(posedge clk); while (!nbr_bus.ready);
    predict_densities(n);
  endtask

  // drop valid, wait for every result, then let a non-result item finish
  task automatic wait_idle(input int settle);
    nbr_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_setting(input setting_t s);
    logic [2:0]  idx [7];
    logic [30:0] val [7];
    idx = '{REG_RADIUS, REG_INV_RADIUS, REG_DENS_GAIN, REG_NEAR_GAIN,
            REG_STIFF, REG_REST, REG_NEAR_STIFF};
    val = '{s.radius, s.inv_radius, s.dens_gain, s.near_gain, s.stiff, s.rest, s.near_stiff};
    for (int i = 0; i < 7; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= val[i];
      do @(posedge clk); while (!cfg_bus.ready);
      case (idx[i])
        REG_RADIUS:     cur.radius     = val[i];
        REG_INV_RADIUS: cur.inv_radius = val[i];
        REG_DENS_GAIN:  cur.dens_gain  = val[i];
        REG_NEAR_GAIN:  cur.near_gain  = val[i];
        REG_STIFF:      cur.stiff      = val[i];
        REG_REST:       cur.rest       = val[i];
        REG_NEAR_STIFF: cur.near_stiff = val[i];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // cutoff boundaries and coincident pairs under the reset setting
  task automatic test_reset_setting_cases();
    send_neighbor(make_neighbor(0, 0, 0, 0, MASS_MAX, 0));
    send_neighbor(make_neighbor(100, 200, 105, 204, MASS_MAX, 0));
    send_neighbor(make_neighbor(100, 200, 106, 203, MASS_MAX, 0));
    send_neighbor(make_neighbor(0, 0, 65536, 0, MASS_MAX, 0));
    send_neighbor(make_neighbor(0, 0, 65536, 1, MASS_MAX, 0));
    send_neighbor(make_neighbor(0, 0, -65537, 0, MASS_MAX, 0));
    send_neighbor(make_neighbor(0, 0, 0, -65536, MASS_MAX, 0));
    send_neighbor(make_neighbor(-1000, -1000, 31768, 31768, MASS_MAX, 1));
    send_neighbor(make_neighbor(NEG_MAX, POS_MAX, POS_MAX, NEG_MAX, MASS_MAX, 0));
    send_neighbor(make_neighbor(POS_MAX, NEG_MAX, POS_MAX - 100, NEG_MAX + 100, 0, 1));
    send_neighbor(make_neighbor(5000, -5000, 25000, -15000, 1, 1));
    send_neighbor(make_neighbor(0, 0, POS_MAX, 0, MASS_MAX, 1));
  endtask

  task automatic test_extreme_settings();
    // sums and pressures driven into saturation
    wait_idle(DRAIN_CYCLES);
    load_setting('{REG_MAX, 31'd1, REG_MAX, REG_MAX, REG_MAX, 31'd0, REG_MAX});
    send_neighbor(make_neighbor(0, 0, 1000, 0, MASS_MAX, 0));
    send_neighbor(make_neighbor(NEG_MAX, 0, POS_MAX, 0, MASS_MAX, 0));
    send_neighbor(make_neighbor(-300, 400, 300, -400, MASS_MAX, 1));
    // zero density against the largest rest density
    wait_idle(DRAIN_CYCLES);
    load_setting('{31'd65536, 31'd65536, 31'd0, 31'd0, REG_MAX, REG_MAX, 31'd0});
    send_neighbor(make_neighbor(0, 0, 100, 100, MASS_MAX, 1));
    // 1 - r/h below zero clamps to zero but the pair still counts
    wait_idle(DRAIN_CYCLES);
    load_setting('{31'd1048576, REG_MAX, 31'd208605, 31'd312907, 31'd65536, 31'd655360,
                   31'd65536});
    send_neighbor(make_neighbor(0, 0, 3, 7, MASS_MAX, 0));
    send_neighbor(make_neighbor(0, 0, 524288, 0, MASS_MAX, 1));
    // smallest radius keeps nothing
    wait_idle(DRAIN_CYCLES);
    load_setting('{31'd1, 31'd1, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0});
    send_neighbor(make_neighbor(0, 0, 1, 0, MASS_MAX, 0));
    send_neighbor(make_neighbor(0, 0, 0, 0, MASS_MAX, 0));
    send_neighbor(make_neighbor(10, 10, 10, 11, MASS_MAX, 1));
  endtask

  // every pair kept, so the count reaches its cap and holds there
  task automatic test_kept_limit();
    longint cx, cy, ox, oy;
    int     len;
    wait_idle(DRAIN_CYCLES);
    load_setting(RESET_SETTING);
    for (int run = 0; run < 2; run++) begin
      len = (run == 0) ? 64 : 70;
      for (int i = 0; i < len; i++) begin
        cx = longint'($signed($urandom)) >>> 1;
        cy = longint'($signed($urandom)) >>> 1;
        ox = longint'($urandom_range(8, 30000));
        oy = longint'($urandom_range(0, 30000));
        if ($urandom_range(0, 1) == 1) ox = -ox;
        if ($urandom_range(0, 1) == 1) oy = -oy;
        send_neighbor(make_neighbor(cx, cy, cx + ox, cy + oy, 31'($urandom), i == len - 1));
      end
    end
  endtask

  task automatic test_random_runs();
    setting_t s;
    int       sent;
    int       len;
    int       roll;
    bit       paused;
    paused = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle(DRAIN_CYCLES);
      s = random_setting();
      if (ph == 3) s.radius = REG_MAX;
      load_setting(s);
      steady_flow = (ph == 2);
      sent = 0;
      while (sent < 120) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) len = $urandom_range(1, 10);
        else if (roll < 96) len = $urandom_range(11, 30);
        else len = $urandom_range(60, 72);
        // hold the sender once until the block has nothing pending
        if (ph == 1 && !paused && sent >= 60) begin
          wait_idle(0);
          paused = 1'b1;
        end
        for (int i = 0; i < len; i++) send_neighbor(random_neighbor(i == len - 1));
        sent += len;
      end
    end
    steady_flow = 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    densities_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result item with none expected: expected nothing, actual %h %h %h %h %0d",
                 $time, res_bus.density, res_bus.near_density, res_bus.pressure,
                 res_bus.near_pressure, res_bus.kept_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("density", want.density, res_bus.density);
        check_field("near_density", want.near_density, res_bus.near_density);
        check_field("pressure", want.pressure, res_bus.pressure);
        check_field("near_pressure", want.near_pressure, res_bus.near_pressure);
        check_field("kept_count", 32'(want.kept_count), 32'(res_bus.kept_count));
      end
    end
  end

  initial begin : result_ready_driver
    int stall_left;
    res_bus.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (nbr_bus.valid && nbr_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                   = 1'b1;
    nbr_bus.valid         = 1'b0;
    nbr_bus.center_x      = '0;
    nbr_bus.center_y      = '0;
    nbr_bus.neighbor_x    = '0;
    nbr_bus.neighbor_y    = '0;
    nbr_bus.neighbor_mass = '0;
    nbr_bus.last_neighbor = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = REG_RADIUS;
    cfg_bus.data          = '0;
    cur                   = RESET_SETTING;
    acc_density           = '0;
    acc_near              = '0;
    acc_kept              = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_setting_cases();
    test_extreme_settings();
    test_kept_limit();
    test_random_runs();

    wait_idle(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/sdpa_pkg.sv
design/sdpa_in_if.sv
design/sdpa_out_if.sv
design/sdpa_cfg_if.sv
design/sph_density_pressure_accumulator_top.sv
verif/sph_density_pressure_accumulator_top_tb.sv
